// ----- hw/rtl/earliest_free_room_scheduler_macros.svh -----
// ----------------------------------------------------------------------------
// Earliest free room scheduler assertion macros
// Concurrent assertion helpers, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef EARLIEST_FREE_ROOM_SCHEDULER_MACROS_SVH
`define EARLIEST_FREE_ROOM_SCHEDULER_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication.
`define ERFS_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ERFS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ERFS_ASSERT(lbl, ante, cons, msg)
`define ERFS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ----- hw/rtl/erfs_pkg.sv -----
// ----------------------------------------------------------------------------
// Earliest free room scheduler package
// Sizes, payload structs and the token that sweeps along the room cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package erfs_pkg;

	localparam int MAX_ROOMS = 16;
	localparam int IDX_W     = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1;
	localparam int TIME_W    = 48;
	localparam int IN_TIME_W = 32;
	localparam int CNT_W     = 16;
	localparam int ROOM_W    = 4;
	localparam int CFG_W     = 5;

	localparam logic [CFG_W-1:0] NUM_ROOMS_RESET = CFG_W'(16);
	localparam logic             CMD_SCHEDULE    = 1'b0;
	localparam logic             CMD_CLEAR       = 1'b1;

	typedef struct packed {
		logic                 command;
		logic [IN_TIME_W-1:0] start_time;
		logic [IN_TIME_W-1:0] end_time;
	} job_t;

	typedef struct packed {
		logic [ROOM_W-1:0] assigned_room;
		logic [TIME_W-1:0] finish_time;
		logic              was_delayed;
		logic [ROOM_W-1:0] most_booked_room;
		logic [CNT_W-1:0]  most_booked_count;
	} res_t;

	// Search record handed from cell to cell.
	typedef struct packed {
		logic              valid;
		logic              found;
		logic [IDX_W-1:0]  pick;
		logic [TIME_W-1:0] min_time;
		logic [CNT_W-1:0]  cnt;
	} tok_t;

	// Write-back broadcast to all cells.
	typedef struct packed {
		logic              clear;
		logic              we;
		logic [IDX_W-1:0]  pick;
		logic [TIME_W-1:0] free_time;
		logic [CNT_W-1:0]  cnt;
	} wr_t;

endpackage

// ----- hw/rtl/earliest_free_room_scheduler.sv -----
// ----------------------------------------------------------------------------
// Earliest free room scheduler
// Assigns each job to the first free enabled room, or delays it on the room
// that frees earliest, tracks the most booked room, and clears all rooms on a clear command.
// ----------------------------------------------------------------------------
// Usage:
//   job channel (job_valid/job_ready/job) takes one job or clear command per
//   transfer. res channel (res_valid/res_ready/res) returns exactly one result
//   per job. cfg channel (cfg_valid/cfg_ready/cfg_data) writes num_rooms; it is
//   always ready; the user must write it only while no job is in flight, as
//   the block does not enforce this. A job token walks the chain of room
//   cells, one cell per cycle. A clear command skips the chain and goes
//   straight to write-back. job_ready is high only while no job is in flight,
//   so a new job is taken only once the last one has passed write-back. A
//   result held by a stalled receiver does not block the next job's search;
//   only its write-back waits until the output register is free.
//   Reset clears all room times and counts, the most booked room and count,
//   and sets num_rooms to 16.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "earliest_free_room_scheduler_macros.svh"

module earliest_free_room_scheduler
	import erfs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             job_valid,
	output logic             job_ready,
	input  job_t             job,
	output logic             res_valid,
	input  logic             res_ready,
	output res_t             res,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SWEEP,
		S_WRITE
	} state_t;

	state_t             state_q;
	logic [CFG_W-1:0]   num_rooms_q;
	logic [CFG_W-1:0]   n_eff;
	logic [MAX_ROOMS-1:0] en;
	job_t               job_q;
	logic               launch_q;
	tok_t               cap_q;
	tok_t               chain [MAX_ROOMS+1];
	logic [MAX_ROOMS-1:0] chain_valid;
	wr_t                wr;
	res_t               res_q;
	logic               res_valid_q;
	logic [IDX_W-1:0]   best_room_q;
	logic [CNT_W-1:0]   best_cnt_q;

	logic               job_fire;
	logic               wr_go;
	logic [IN_TIME_W-1:0] dur;
	logic [TIME_W:0]    sum;
	logic [TIME_W-1:0]  new_free;
	logic [CNT_W-1:0]   new_cnt;
	logic [IDX_W-1:0]   best_room_nxt;
	logic [CNT_W-1:0]   best_cnt_nxt;

	assign job_ready = (state_q == S_IDLE);
	assign job_fire  = job_valid && job_ready;
	assign cfg_ready = 1'b1;
	assign wr_go     = (state_q == S_WRITE) && (!res_valid_q || res_ready);

	// Out-of-range room counts clamp to one and to MAX_ROOMS.
	always_comb begin
		if (num_rooms_q == '0) begin
			n_eff = CFG_W'(1);
		end else if (32'(num_rooms_q) > MAX_ROOMS) begin
			n_eff = CFG_W'(MAX_ROOMS);
		end else begin
			n_eff = num_rooms_q;
		end
	end

	assign chain[0] = tok_t'{valid: launch_q, default: '0};

	for (genvar r = 0; r < MAX_ROOMS; r++) begin : g_cell
		assign en[r]          = (32'(r) < 32'(n_eff));
		assign chain_valid[r] = chain[r+1].valid;

		erfs_room_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.room_id   (IDX_W'(r)),
			.en        (en[r]),
			.start_time(job_q.start_time),
			.tok_in    (chain[r]),
			.tok_out   (chain[r+1]),
			.wr        (wr)
		);
	end

	// Write-back values from the captured search record.
	always_comb begin
		dur = (job_q.end_time > job_q.start_time) ? (job_q.end_time - job_q.start_time) : '0;
		sum = {1'b0, cap_q.min_time} + (TIME_W + 1)'(dur);
		if (cap_q.found) begin
			new_free = TIME_W'(job_q.end_time);
		end else if (sum[TIME_W]) begin
			new_free = '1;
		end else begin
			new_free = sum[TIME_W-1:0];
		end
		new_cnt = (cap_q.cnt == '1) ? cap_q.cnt : cap_q.cnt + 1'b1;

		best_room_nxt = best_room_q;
		best_cnt_nxt  = best_cnt_q;
		if (new_cnt > best_cnt_q || (new_cnt == best_cnt_q && cap_q.pick < best_room_q)) begin
			best_room_nxt = cap_q.pick;
			best_cnt_nxt  = new_cnt;
		end else if (cap_q.pick == best_room_q) begin
			best_cnt_nxt = new_cnt;
		end

		wr           = '0;
		wr.clear     = wr_go && (job_q.command == CMD_CLEAR);
		wr.we        = wr_go && (job_q.command == CMD_SCHEDULE);
		wr.pick      = cap_q.pick;
		wr.free_time = new_free;
		wr.cnt       = new_cnt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			num_rooms_q <= NUM_ROOMS_RESET;
			launch_q    <= 1'b0;
			res_valid_q <= 1'b0;
			best_room_q <= '0;
			best_cnt_q  <= '0;
		end else begin
			launch_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				num_rooms_q <= cfg_data;
			end
			if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (job_fire) begin
						if (job.command == CMD_CLEAR) begin
							state_q <= S_WRITE;
						end else begin
							launch_q <= 1'b1;
							state_q  <= S_SWEEP;
						end
					end
				end
				S_SWEEP: begin
					if (chain[MAX_ROOMS].valid) begin
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					if (wr_go) begin
						res_valid_q <= 1'b1;
						state_q     <= S_IDLE;
						if (job_q.command == CMD_CLEAR) begin
							best_room_q <= '0;
							best_cnt_q  <= '0;
						end else begin
							best_room_q <= best_room_nxt;
							best_cnt_q  <= best_cnt_nxt;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (job_fire) begin
			job_q <= job;
		end
		if (state_q == S_SWEEP && chain[MAX_ROOMS].valid) begin
			cap_q <= chain[MAX_ROOMS];
		end
		if (wr_go) begin
			if (job_q.command == CMD_CLEAR) begin
				res_q <= '0;
			end else begin
				res_q.assigned_room     <= ROOM_W'(cap_q.pick);
				res_q.finish_time       <= new_free;
				res_q.was_delayed       <= !cap_q.found;
				res_q.most_booked_room  <= ROOM_W'(best_room_nxt);
				res_q.most_booked_count <= best_cnt_nxt;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// At most one search token is on the chain at a time.
	`ERFS_ASSERT(a_one_token, 1'b1, $countones({chain_valid, launch_q}) <= 1,
		"more than one search token in the room chain")
	// Nothing is in flight while new jobs are taken.
	`ERFS_ASSERT(a_idle_empty, job_ready, (chain_valid == '0) && !launch_q,
		"job accepted while a search is still running")
	// The end of the chain always moves the sequencer to write-back.
	`ERFS_ASSERT_NEXT(a_sweep_done, state_q == S_SWEEP && chain[MAX_ROOMS].valid,
		state_q == S_WRITE, "search result not taken for write-back")

endmodule

// ----- hw/rtl/erfs_room_cell.sv -----
// ----------------------------------------------------------------------------
// Room cell
// Holds one room's free time and use count and steps the search token on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module erfs_room_cell
	import erfs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [IDX_W-1:0]     room_id,
	input  logic                 en,
	input  logic [IN_TIME_W-1:0] start_time,
	input  tok_t                 tok_in,
	output tok_t                 tok_out,
	input  wr_t                  wr
);

	logic [TIME_W-1:0] free_q;
	logic [CNT_W-1:0]  cnt_q;
	tok_t              tok_nxt;
	tok_t              tok_s1;

	always_comb begin
		tok_nxt = tok_in;
		if (tok_in.valid && en && !tok_in.found) begin
			if (free_q <= TIME_W'(start_time)) begin
				tok_nxt.found = 1'b1;
				tok_nxt.pick  = room_id;
				tok_nxt.cnt   = cnt_q;
			end else if (room_id == '0 || free_q < tok_in.min_time) begin
				// Room zero opens the minimum search, since it is always enabled.
				tok_nxt.min_time = free_q;
				tok_nxt.pick     = room_id;
				tok_nxt.cnt      = cnt_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
			free_q <= '0;
			cnt_q  <= '0;
		end else begin
			tok_s1 <= tok_nxt;
			if (wr.clear) begin
				free_q <= '0;
				cnt_q  <= '0;
			end else if (wr.we && wr.pick == room_id) begin
				free_q <= wr.free_time;
				cnt_q  <= wr.cnt;
			end
		end
	end

	assign tok_out = tok_s1;

endmodule
